// ===== hdl/ccalloc_pkg.sv =====
// ccalloc_pkg: types and constants shared by the cluster chain allocator
// operation and status codes, response word layout, entry marks
// no dependencies
`default_nettype none

package ccalloc_pkg;

   localparam int CLUSTER_W  = 12;
   localparam int ENTRY_W    = 28;
   localparam int LIMIT_W    = 13;
   localparam int FIRST_DATA = 2;

   localparam logic [ENTRY_W-1:0] END_MARK    = 28'hFFFFFFF;
   localparam logic [ENTRY_W-1:0] END_MIN     = 28'hFFFFFF8;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd4096;

   // register index codes, taken from csr_paddr[2]
   localparam logic REG_ENABLED = 1'b0;
   localparam logic REG_LIMIT   = 1'b1;

   typedef enum logic [1:0] {
      OP_ALLOC = 2'd0,
      OP_LINK  = 2'd1,
      OP_FREE  = 2'd2,
      OP_WRITE = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_OFF  = 2'd1,
      ST_FULL = 2'd2,
      ST_BAD  = 2'd3
   } status_type;

   // ok in bit 0, status above it, cluster number on top
   typedef struct packed {
      logic [CLUSTER_W-1:0] cluster_out;
      status_type           status;
      logic                 ok;
   } rsp_type;

   function automatic rsp_type make_rsp(status_type st, logic [CLUSTER_W-1:0] cl);
      rsp_type r;
      r.ok          = (st == ST_OK);
      r.status      = st;
      r.cluster_out = cl;
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/ccalloc_table.sv =====
// ccalloc_table: single-clock allocation table memory
// one write and one registered read per cycle; no package needed
`default_nettype none

module ccalloc_table #(
   parameter int DEPTH = 4096,
   parameter int WIDTH = 28,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              we,
   input  wire logic [ADDR_W-1:0] waddr,
   input  wire logic [WIDTH-1:0]  wdata,
   input  wire logic              re,
   input  wire logic [ADDR_W-1:0] raddr,
   output logic      [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

`default_nettype wire

// ===== hdl/ccalloc_seq.sv =====
// ccalloc_seq: sequencer for the allocator; clearing pass, first-fit scan,
// link write, chain walk and raw entry write over the table memory
// depends on ccalloc_pkg
`default_nettype none

module ccalloc_seq #(
   parameter int TABLE_DEPTH = 4096,
   parameter int CHAIN_GUARD = 4096,
   localparam int ADDR_W = $clog2(TABLE_DEPTH)
) (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire logic                                     req_valid,
   output logic                                          req_ready,
   input  wire ccalloc_pkg::op_type                      req_op,
   input  wire logic [ccalloc_pkg::CLUSTER_W-1:0]        req_cl,
   input  wire logic [ccalloc_pkg::ENTRY_W-1:0]          req_val,
   input  wire logic                                     enabled,
   input  wire logic [ccalloc_pkg::LIMIT_W-1:0]          limit,
   input  wire logic                                     rsp_free,
   output logic                                          done,
   output ccalloc_pkg::rsp_type                          result,
   output logic                                          mem_we,
   output logic      [ADDR_W-1:0]                        mem_waddr,
   output logic      [ccalloc_pkg::ENTRY_W-1:0]          mem_wdata,
   output logic                                          mem_re,
   output logic      [ADDR_W-1:0]                        mem_raddr,
   input  wire logic [ccalloc_pkg::ENTRY_W-1:0]          mem_rdata
);

   import ccalloc_pkg::*;

   localparam int LIM_W   = (ADDR_W + 1 > LIMIT_W) ? ADDR_W + 1 : LIMIT_W;
   localparam int GUARD_W = $clog2(CHAIN_GUARD + 1);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_LINK,
      S_FREE,
      S_DONE
   } state_type;

   state_type            state_ff;
   logic [ADDR_W-1:0]    clr_ff;
   logic [LIM_W-1:0]     scan_ff;
   logic [LIM_W-1:0]     tag_ff;
   logic [GUARD_W-1:0]   count_ff;
   op_type               op_ff;
   logic [CLUSTER_W-1:0] cl_ff;
   rsp_type              res_ff;

   logic [LIM_W-1:0]     lim;
   logic [LIM_W-1:0]     cl_ext;
   logic [LIM_W-1:0]     link_ext;
   logic                 accept;
   logic                 cl_low;
   logic                 cl_bad;
   logic                 scan_hit;
   logic                 scan_end;
   logic                 nxt_stop;
   status_type           idle_st;
   state_type            idle_next;

   always_comb begin
      lim      = (LIM_W'(limit) > LIM_W'(TABLE_DEPTH)) ? LIM_W'(TABLE_DEPTH) : LIM_W'(limit);
      cl_ext   = LIM_W'(req_cl);
      link_ext = LIM_W'(cl_ff);
      req_ready = (state_ff == S_IDLE);
      accept    = req_valid && req_ready;
      cl_low    = cl_ext < LIM_W'(FIRST_DATA);
      cl_bad    = cl_ext >= lim;
      scan_hit  = (mem_rdata == '0);
      scan_end  = (tag_ff == lim - LIM_W'(1));
      // the walk ends on a self link, a reserved or end value, a link off the
      // table, or when the guard count is used up
      nxt_stop  = (mem_rdata == ENTRY_W'(tag_ff)) ||
                  (mem_rdata < ENTRY_W'(FIRST_DATA)) ||
                  (mem_rdata >= END_MIN) ||
                  (mem_rdata >= ENTRY_W'(lim)) ||
                  (count_ff == GUARD_W'(CHAIN_GUARD - 1));
      done   = (state_ff == S_DONE) && rsp_free;
      result = res_ff;
   end

   // outcome of an accepted word before any table access
   always_comb begin
      idle_st   = ST_OK;
      idle_next = S_DONE;
      if (!enabled) begin
         idle_st = ST_OFF;
      end else begin
         case (req_op)
            OP_ALLOC, OP_LINK: begin
               if (req_op == OP_LINK && (cl_low || cl_bad)) begin
                  idle_st = ST_BAD;
               end else if (lim <= LIM_W'(FIRST_DATA)) begin
                  idle_st = ST_FULL;
               end else begin
                  idle_next = S_SCAN;
               end
            end
            OP_FREE: begin
               if (!cl_low) begin
                  if (cl_bad) begin
                     idle_st = ST_BAD;
                  end else begin
                     idle_next = S_FREE;
                  end
               end
            end
            OP_WRITE: begin
               if (cl_bad) begin
                  idle_st = ST_BAD;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = '0;
      mem_wdata = '0;
      mem_re    = 1'b0;
      mem_raddr = '0;
      case (state_ff)
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
         end
         S_IDLE: begin
            // speculative first read: chain start or first data entry
            mem_re    = 1'b1;
            mem_raddr = (req_op == OP_FREE) ? cl_ext[ADDR_W-1:0] : ADDR_W'(FIRST_DATA);
            if (accept && enabled && req_op == OP_WRITE && !cl_bad) begin
               mem_we    = 1'b1;
               mem_waddr = cl_ext[ADDR_W-1:0];
               mem_wdata = req_val;
            end
         end
         S_SCAN: begin
            mem_re    = (scan_ff < lim);
            mem_raddr = scan_ff[ADDR_W-1:0];
            if (scan_hit) begin
               mem_we    = 1'b1;
               mem_waddr = tag_ff[ADDR_W-1:0];
               mem_wdata = END_MARK;
            end
         end
         S_LINK: begin
            mem_we    = 1'b1;
            mem_waddr = link_ext[ADDR_W-1:0];
            mem_wdata = ENTRY_W'(tag_ff);
         end
         S_FREE: begin
            mem_we    = 1'b1;
            mem_waddr = tag_ff[ADDR_W-1:0];
            if (!nxt_stop) begin
               mem_re    = 1'b1;
               mem_raddr = mem_rdata[ADDR_W-1:0];
            end
         end
         S_DONE: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
      end else begin
         case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + ADDR_W'(1);
               if (clr_ff == ADDR_W'(TABLE_DEPTH - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (accept) begin
                  op_ff    <= req_op;
                  cl_ff    <= req_cl;
                  tag_ff   <= (req_op == OP_FREE) ? cl_ext : LIM_W'(FIRST_DATA);
                  scan_ff  <= LIM_W'(FIRST_DATA + 1);
                  count_ff <= '0;
                  res_ff   <= make_rsp(idle_st, '0);
                  state_ff <= idle_next;
               end
            end
            S_SCAN: begin
               if (scan_hit) begin
                  if (op_ff == OP_LINK) begin
                     state_ff <= S_LINK;
                  end else begin
                     res_ff   <= make_rsp(ST_OK, tag_ff[CLUSTER_W-1:0]);
                     state_ff <= S_DONE;
                  end
               end else begin
                  tag_ff  <= scan_ff;
                  scan_ff <= scan_ff + LIM_W'(1);
                  if (scan_end) begin
                     res_ff   <= make_rsp(ST_FULL, '0);
                     state_ff <= S_DONE;
                  end
               end
            end
            S_LINK: begin
               res_ff   <= make_rsp(ST_OK, tag_ff[CLUSTER_W-1:0]);
               state_ff <= S_DONE;
            end
            S_FREE: begin
               if (nxt_stop) begin
                  state_ff <= S_DONE;
               end else begin
                  tag_ff   <= mem_rdata[LIM_W-1:0];
                  count_ff <= count_ff + GUARD_W'(1);
               end
            end
            S_DONE: begin
               if (rsp_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

// ===== hdl/cluster_chain_allocator.sv =====
// cluster_chain_allocator: first-fit cluster allocator over a 28-bit entry table
// holds the register port and the result register; depends on ccalloc_pkg,
// ccalloc_seq and ccalloc_table
//
// Usage:
//  - req_ channel carries one operation word (allocate, allocate and link,
//    free chain, write entry); rsp_ channel returns one result word for each.
//  - csr_ port holds enabled (address 0) and cluster_limit (address 4);
//    write them only while no operation is outstanding.
//  - After reset the table is cleared one entry per cycle: req_tready stays
//    low until the clearing pass ends; register writes are taken during that time.
//  - Rejected operations, write entry and free from below 2 go from accept
//    straight to the result; allocate reads the table entry by entry from
//    the first data entry until a free cluster is found or the effective
//    limit is reached, and for link the link entry is then written; free chain
//    walks the chain and clears each entry visited, reading one entry per cycle.
//  - One operation is in flight at a time; the next is accepted once the
//    previous result has been moved into the result register, so a stalled
//    receiver holds rsp_tdata stable and delays only completion.
`default_nettype none

module cluster_chain_allocator #(
   parameter int TABLE_DEPTH = 4096,
   parameter int CHAIN_GUARD = 4096
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [47:0] req_tdata,   // op[1:0], cluster[13:2], value[41:14]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [15:0] rsp_tdata,   // ok[0], status[2:1], cluster_out[14:3]
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic      [31:0] csr_prdata,
   output logic             csr_pready
);

   import ccalloc_pkg::*;

   localparam int ADDR_W = $clog2(TABLE_DEPTH);

   logic               enabled_ff;
   logic [LIMIT_W-1:0] limit_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff;

   logic               csr_write;
   logic               rsp_free;
   logic               done;
   rsp_type            result;
   logic               mem_we;
   logic [ADDR_W-1:0]  mem_waddr;
   logic [ENTRY_W-1:0] mem_wdata;
   logic               mem_re;
   logic [ADDR_W-1:0]  mem_raddr;
   logic [ENTRY_W-1:0] mem_rdata;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      case (csr_paddr[2])
         REG_ENABLED: csr_prdata = {31'd0, enabled_ff};
         REG_LIMIT:   csr_prdata = {{(32 - LIMIT_W){1'b0}}, limit_ff};
         default:     csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff <= 1'b0;
         limit_ff   <= LIMIT_RESET;
      end else if (csr_write) begin
         case (csr_paddr[2])
            REG_ENABLED: enabled_ff <= csr_pwdata[0];
            REG_LIMIT:   limit_ff   <= csr_pwdata[LIMIT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // result register parts the sequencer from the receiver
   assign rsp_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_data_ff};

   ccalloc_seq #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .CHAIN_GUARD (CHAIN_GUARD)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_op    (op_type'(req_tdata[1:0])),
      .req_cl    (req_tdata[13:2]),
      .req_val   (req_tdata[41:14]),
      .enabled   (enabled_ff),
      .limit     (limit_ff),
      .rsp_free  (rsp_free),
      .done      (done),
      .result    (result),
      .mem_we    (mem_we),
      .mem_waddr (mem_waddr),
      .mem_wdata (mem_wdata),
      .mem_re    (mem_re),
      .mem_raddr (mem_raddr),
      .mem_rdata (mem_rdata)
   );

   ccalloc_table #(
      .DEPTH (TABLE_DEPTH),
      .WIDTH (ENTRY_W)
   ) u_table (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

endmodule

`default_nettype wire

// ===== hdl/ccalloc_checker.sv =====
// ccalloc_checker: port-level checks on the cluster chain allocator
// depends on ccalloc_pkg; bound to cluster_chain_allocator below
`default_nettype none

module ccalloc_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [15:0] rsp_tdata
);

   import ccalloc_pkg::*;

   // a result word held by the receiver stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed while stalled");

   a_ok_match: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[0] == (rsp_tdata[2:1] == ST_OK))
      else $error("ok flag disagrees with status");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2:1] != ST_OK |-> rsp_tdata[14:3] == '0)
      else $error("failed operation returned a cluster number");

   // the clearing pass keeps the block closed right after reset
   a_reset_closed: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_tvalid && !req_tready)
      else $error("block open straight after reset");

endmodule

bind cluster_chain_allocator ccalloc_checker u_ccalloc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
